// ----- sv/gvt_pkg.sv -----
package gvt_pkg;

  localparam int IDX_W  = 6;
  localparam int TIME_W = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } gvt_state_t;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_beat_t;

endpackage

// ----- sv/gvt_ram.sv -----
module gvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/gvt_min_unit.sv -----
module gvt_min_unit
  import gvt_pkg::*;
(
  input  logic                     clk,
  input  scan_beat_t               beat,
  input  logic [TIME_W-1:0]        rdata,
  output logic signed [TIME_W-1:0] min_time
);

  logic signed [TIME_W-1:0] sample;

  assign sample = $signed(rdata);

  always_ff @(posedge clk) begin
    if (beat.valid) begin
      if (beat.first || (sample < min_time)) begin
        min_time <= sample;
      end
    end
  end

endmodule

// ----- sv/gvt_min_tracker.sv -----
// Global virtual time tracker.
// Input channel (in_valid/in_ready): process_index and local_time report the
// new local time of one logical process. Output channel (out_valid/out_ready):
// new_global_time, sent only when the global time rises.
// Each transfer writes the local time into a single-port-write RAM, then the
// whole RAM is read back one entry per cycle while a running minimum is kept.
// An item is not taken until the last one is through: after a transfer the
// tracker passes through ST_SCAN, ST_DRAIN and ST_FINISH before in_ready rises
// again in ST_IDLE; the result is loaded into the output register in ST_FINISH.
// A report with process_index >= PROCESS_COUNT leaves the RAM unchanged.
// Reset (rst, synchronous) zeroes the global time and starts a clearing pass
// that writes zero into every RAM entry, one per cycle; in_ready stays low
// during the pass.
// The result sits in an output register. While the receiver stalls, the next
// item is still taken and scanned; only a second rising result waits for the
// register to drain before it is loaded.
module gvt_min_tracker
  import gvt_pkg::*;
#(
  parameter int PROCESS_COUNT = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IDX_W-1:0]         process_index,
  input  logic signed [TIME_W-1:0] local_time,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TIME_W-1:0] new_global_time
);

  localparam int ADDR_W = $clog2(PROCESS_COUNT);
  localparam int WIDE_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

  gvt_state_t state, state_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  scan_beat_t beat, beat_next;
  logic signed [TIME_W-1:0] global_time;
  logic signed [TIME_W-1:0] min_time;
  logic [TIME_W-1:0] rdata;
  logic [WIDE_W-1:0] idx_wide;
  logic idx_ok;
  logic cnt_last;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [TIME_W-1:0] wdata;
  logic raise;
  logic load_out;

  assign idx_wide = WIDE_W'(process_index);
  assign idx_ok   = 32'(process_index) < 32'(PROCESS_COUNT);
  assign cnt_last = cnt == ADDR_W'(PROCESS_COUNT - 1);
  assign raise    = min_time > global_time;

  gvt_ram #(
    .WIDTH(TIME_W),
    .DEPTH(PROCESS_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(cnt),
    .rdata(rdata)
  );

  gvt_min_unit u_min (
    .clk     (clk),
    .beat    (beat),
    .rdata   (rdata),
    .min_time(min_time)
  );

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    beat_next  = '0;
    in_ready   = 1'b0;
    we         = 1'b0;
    waddr      = cnt;
    wdata      = '0;
    load_out   = 1'b0;
    case (state)
      ST_CLEAR: begin
        we       = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        waddr    = idx_wide[ADDR_W-1:0];
        wdata    = local_time;
        if (in_valid) begin
          we         = idx_ok;
          cnt_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        beat_next.valid = 1'b1;
        beat_next.first = cnt == '0;
        cnt_next        = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!raise) begin
          state_next = ST_IDLE;
        end else if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      beat        <= '0;
      global_time <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      beat  <= beat_next;
      if (load_out) begin
        global_time <= min_time;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      new_global_time <= min_time;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import gvt_pkg::*;

  localparam int     PROC_N     = 64;
  localparam int     MAX_CYCLES = 400000;
  localparam longint LVT_TOP    = 64'sd2147483647;
  localparam longint LVT_BOTTOM = -64'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [TIME_W-1:0] lvt;
    bit                       hold;
  } lvt_report_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [IDX_W-1:0]         process_index = '0;
  logic signed [TIME_W-1:0] local_time = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TIME_W-1:0] new_global_time;

  lvt_report_t              report_q[$];
  logic signed [TIME_W-1:0] gvt_expected[$];
  logic signed [TIME_W-1:0] lvt_shadow[PROC_N];
  logic signed [TIME_W-1:0] gvt_shadow;
  longint                   lvt_plan[PROC_N];
  int                       errors = 0;
  int                       cycle_cnt = 0;
  int                       accepted_cnt = 0;
  int                       send_wait = 0;
  int                       recv_wait = 0;

  gvt_min_tracker #(.PROCESS_COUNT(PROC_N)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .process_index   (process_index),
    .local_time      (local_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .new_global_time (new_global_time)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic advance_gvt(input logic [IDX_W-1:0] idx,
                             input logic signed [TIME_W-1:0] lvt);
    logic signed [TIME_W-1:0] low;
    if (int'(idx) < PROC_N)
      lvt_shadow[idx] = lvt;
    low = lvt_shadow[0];
    for (int k = 1; k < PROC_N; k++)
      if (lvt_shadow[k] < low)
        low = lvt_shadow[k];
    if (low > gvt_shadow) begin
      gvt_shadow = low;
      gvt_expected.push_back(low);
    end
  endtask

  function automatic int draw_gap();
    if (cycle_cnt % 3000 < 500)
      return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic queue_report(input int idx, input longint lvt, input bit hold = 1'b0);
    lvt_report_t r;
    r.idx  = idx[IDX_W-1:0];
    r.lvt  = lvt[TIME_W-1:0];
    r.hold = hold;
    report_q.push_back(r);
    if (idx < PROC_N)
      lvt_plan[idx] = r.lvt;
  endtask

  // advance the lagging process to at or just past the next-lowest one
  task automatic queue_advance(input bit hold);
    int     lo;
    longint second;
    longint nxt;
    lo = 0;
    for (int k = 1; k < PROC_N; k++)
      if (lvt_plan[k] < lvt_plan[lo])
        lo = k;
    second = LVT_TOP;
    for (int k = 0; k < PROC_N; k++)
      if (k != lo && lvt_plan[k] < second)
        second = lvt_plan[k];
    nxt = second + $urandom_range(0, 2000);
    if (nxt > LVT_TOP)
      nxt = LVT_TOP;
    queue_report(lo, nxt, hold);
  endtask

  always @(posedge clk) begin : drive
    logic        keep;
    logic        launch;
    lvt_report_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      keep = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        advance_gvt(process_index, local_time);
        accepted_cnt++;
      end
      launch = 1'b0;
      if (!keep) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (report_q.size() > 0 &&
                     (!report_q[0].hold || gvt_expected.size() == 0)) begin
          nxt = report_q.pop_front();
          process_index <= nxt.idx;
          local_time    <= nxt.lvt;
          send_wait = draw_gap();
          launch = 1'b1;
        end
      end
      in_valid <= keep || launch;
    end
  end

  always @(posedge clk) begin : watch
    logic signed [TIME_W-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (gvt_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected global time %0d", new_global_time));
        end else begin
          want = gvt_expected.pop_front();
          if (new_global_time !== want)
            report_mismatch($sformatf("global time %0d, expected %0d",
                                      new_global_time, want));
        end
        recv_wait = draw_gap();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("gvt_min_tracker test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int dice;
    int total;
    for (int k = 0; k < PROC_N; k++) begin
      lvt_shadow[k] = '0;
      lvt_plan[k]   = 0;
    end
    gvt_shadow = '0;

    queue_report(0, 0);
    queue_report(63, LVT_TOP);
    queue_report(0, LVT_BOTTOM);
    queue_report(63, LVT_BOTTOM);
    queue_report(0, -1);
    queue_report(63, 1);
    queue_report(21, 1431655765);
    queue_report(42, -1431655766, 1'b1);
    queue_report(21, -1431655766);
    queue_report(42, 1431655765);
    queue_report(0, 0);
    queue_report(63, 0);
    queue_report(21, 0);
    queue_report(42, 0);

    for (int n = 0; n < 320; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 82)
        queue_advance(n % 100 == 50);
      else if (dice < 94)
        queue_report($urandom_range(0, PROC_N - 1), longint'($signed($urandom())),
                     n % 100 == 50);
      else
        queue_report($urandom_range(0, PROC_N - 1), $urandom_range(0, 50), n % 100 == 50);
    end

    // push every process to the top of the time range
    for (int k = 0; k < PROC_N; k++)
      queue_report(k, LVT_TOP, k == 0);
    queue_report(7, LVT_TOP);
    total = report_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (accepted_cnt < total || gvt_expected.size() != 0)
      @(posedge clk);
    repeat (PROC_N + 8) @(posedge clk);
    if (errors == 0)
      $display("gvt_min_tracker test passed");
    else
      $display("gvt_min_tracker test failed");
    $finish;
  end

endmodule

// ----- gvt_min_tracker.f -----
sv/gvt_pkg.sv
sv/gvt_ram.sv
sv/gvt_min_unit.sv
sv/gvt_min_tracker.sv
sim/tb_top.sv
